### rtl/ufbd_pkg.sv
// ----------------------------------------------------------------------------
// ufbd_pkg
// Widths and constants shared by the fractional baud divisor pipeline.
// ----------------------------------------------------------------------------
package ufbd_pkg;

  // field widths
  localparam int CLK_W  = 30;
  localparam int BAUD_W = 24;
  localparam int INT_W  = 16;
  localparam int FRAC_W = 6;

  // divisor in 64ths that is still in range has INT_W + FRAC_W bits
  localparam int QUO_W  = INT_W + FRAC_W;

  // dividend clock*4 + baud/2 needs one bit over clock*4
  localparam int NUM_W  = CLK_W + 3;

  // trial subtrahend: divisor shifted up to the top quotient bit
  localparam int TRY_W  = BAUD_W + QUO_W;

  // index of the output register in the stage arrays
  localparam int LAST   = QUO_W + 1;

  // reference clock after reset
  localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(48000000);

endpackage

### rtl/uart_fractional_baud_divisor.sv
// ----------------------------------------------------------------------------
// uart_fractional_baud_divisor
// Rounded baud divisor in 64ths, (clock*4 + baud/2) / baud, split into a
// 16-bit integer part and a 6-bit fraction, with range check.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | baud_rate, flow_control
//  out      | out_valid / out_ready| status, divisor_integer, divisor_fraction,
//           |                      | flow_enable
//  cfg      | cfg_we               | cfg_wdata (reference clock in Hz)
//
// one word enters per cycle while in_ready is high; on its way to the output:
// an entry stage forms the dividend, 22 restoring-division stages each
// settle one quotient bit (one 46-bit compare and subtract), and an output
// register applies the range check.
// every stage has its own valid bit and holds only when the one after it is
// full and held, so bubbles close up and a stalled output still lets words in.
// rst clears the valid bits and loads the reference clock with 48 MHz.
// ----------------------------------------------------------------------------
module uart_fractional_baud_divisor
  import ufbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CLK_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BAUD_W-1:0] baud_rate,
  input  logic              flow_control,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              status,
  output logic [INT_W-1:0]  divisor_integer,
  output logic [FRAC_W-1:0] divisor_fraction,
  output logic              flow_enable
);

  logic [CLK_W-1:0]  ref_clock_hz;

  // per-stage state, index 0 is the entry stage
  logic              vld  [0:LAST];
  logic              rdy  [0:LAST];
  logic [NUM_W-1:0]  rem  [0:QUO_W];
  logic [BAUD_W-1:0] dvs  [0:QUO_W];
  logic [QUO_W-1:0]  quo  [0:QUO_W];
  logic              err  [0:QUO_W];
  logic              flow [0:QUO_W];

  logic [NUM_W-1:0]  num;
  logic [INT_W-1:0]  whole;
  logic              bad;

  // reference clock register
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_clock_hz <= CLK_RESET;
    end else if (cfg_we) begin
      ref_clock_hz <= cfg_wdata;
    end
  end

  // a stage may load when it is empty or the next one moves
  assign rdy[LAST] = !vld[LAST] || out_ready;
  for (genvar k = 0; k < LAST; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  assign in_ready = rdy[0];

  // dividend with rounding term
  assign num = {1'b0, ref_clock_hz, 2'b00} + NUM_W'(baud_rate[BAUD_W-1:1]);

  // entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      rem[0]  <= num;
      dvs[0]  <= baud_rate;
      quo[0]  <= '0;
      err[0]  <= (baud_rate == '0);
      flow[0] <= flow_control;
    end
  end

  // restoring division, one quotient bit per stage from the top
  for (genvar s = 1; s <= QUO_W; s++) begin : g_div
    localparam int B = QUO_W - s;

    logic [TRY_W-1:0] trial;
    logic             ge;
    logic             ovf;

    assign trial = TRY_W'(dvs[s-1]) << B;
    assign ge    = TRY_W'(rem[s-1]) >= trial;

    // quotient would need a bit above the top one: integer part too large
    if (s == 1) begin : g_ovf
      assign ovf = TRY_W'(rem[s-1]) >= (TRY_W'(dvs[s-1]) << QUO_W);
    end else begin : g_no_ovf
      assign ovf = 1'b0;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && vld[s-1]) begin
        rem[s]  <= ge ? (rem[s-1] - trial[NUM_W-1:0]) : rem[s-1];
        dvs[s]  <= dvs[s-1];
        quo[s]  <= quo[s-1] | (QUO_W'(ge) << B);
        err[s]  <= err[s-1] | ovf;
        flow[s] <= flow[s-1];
      end
    end
  end

  // range check on the finished quotient
  assign whole = quo[QUO_W][QUO_W-1:FRAC_W];
  assign bad   = err[QUO_W] || (whole == '0);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[LAST] <= 1'b0;
    end else if (rdy[LAST]) begin
      vld[LAST] <= vld[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[LAST] && vld[QUO_W]) begin
      status           <= bad;
      divisor_integer  <= bad ? '0 : whole;
      divisor_fraction <= bad ? '0 : quo[QUO_W][FRAC_W-1:0];
      flow_enable      <= !bad && flow[QUO_W];
    end
  end

  assign out_valid = vld[LAST];

`ifndef ASSERT_OFF
  // a good result always carries a nonzero integer divisor
  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> divisor_integer != '0)
    else $error("ok result with zero integer divisor");

  // an error result carries no divisor and no flow enable
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> divisor_integer == '0 && divisor_fraction == '0
                            && !flow_enable)
    else $error("error result with nonzero fields");

  // an accepted word shows up in the entry stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted word lost at entry");

  // a full last division stage in front of a held output register keeps its word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    vld[QUO_W] && !rdy[LAST] |=> vld[QUO_W] && $stable(quo[QUO_W]))
    else $error("last division stage dropped a word under stall");
`endif

endmodule
